// ----- src/kett_pkg.sv -----
// ----------------------------------------------------------------------------
// kett_pkg: shared types and helpers for the keyed entry table
// Item layouts, operation and status codes, the cell command and scan token,
// and the name cleanup applied before a name is stored.
// ----------------------------------------------------------------------------
package kett_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int NAME_BYTES = 8;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 64;
  localparam int CAP_W      = 6;
  localparam int CNT_OUT_W  = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_DEL,
    KIND_GET,
    KIND_UPD
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_DUP,
    ST_MISSING,
    ST_COLLIDE
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_REPLACE,
    CMD_SHIFT
  } cmd_op_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [KEY_W-1:0]   key;
    logic signed [KEY_W-1:0]   new_key;
    logic        [VAL_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [KEY_W-1:0]   found_key;
    logic        [VAL_W-1:0]   found_value;
    logic        [CNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // Command broadcast to every cell for one cycle after a scan.
  typedef struct packed {
    cmd_op_t            op;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  // Token that walks the cell row once per operation.
  typedef struct packed {
    logic               live;
    logic               hit;
    logic               nhit;
    logic [VAL_W-1:0]   fval;
  } token_t;

  // Keeps the bytes before the first zero byte and below NAME_BYTES.
  function automatic logic [VAL_W-1:0] clean_name(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    logic             ended;
    r     = '0;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= NAME_BYTES || v[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        r[8*b +: 8] = v[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

// ----- src/kett_cell.sv -----
// ----------------------------------------------------------------------------
// kett_cell: one entry slot of the keyed entry table
// Holds one key and name, checks the passing scan token against the query
// keys, hands the token on, and applies the broadcast command.
// ----------------------------------------------------------------------------
module kett_cell #(
  parameter int DEPTH = kett_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kett_pkg::token_t          tok_in,
  output kett_pkg::token_t          tok_out,
  input  logic [kett_pkg::KEY_W-1:0] q_key,
  input  logic [kett_pkg::KEY_W-1:0] q_new_key,
  input  logic [CntW-1:0]           q_count,
  input  kett_pkg::cmd_t            cmd,
  input  logic [kett_pkg::KEY_W-1:0] nbr_key,
  input  logic [kett_pkg::VAL_W-1:0] nbr_value,
  output logic [kett_pkg::KEY_W-1:0] key_out,
  output logic [kett_pkg::VAL_W-1:0] value_out
);
  import kett_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  token_t           tok_r;
  token_t           tok_nxt;
  logic             sel_r;
  logic             after_r;
  logic             in_use;
  logic             key_hit;
  logic             nkey_hit;
  logic             first_hit;

  assign in_use    = MyIdx < q_count;
  assign key_hit   = in_use && (key_r == q_key);
  assign nkey_hit  = in_use && (key_r == q_new_key);
  assign first_hit = tok_in.live && key_hit && !tok_in.hit;

  always_comb begin
    tok_nxt.live = tok_in.live;
    tok_nxt.hit  = tok_in.live && (tok_in.hit || key_hit);
    tok_nxt.nhit = tok_in.live && (tok_in.nhit || nkey_hit);
    tok_nxt.fval = first_hit ? value_r : tok_in.fval;
  end

  // The token also leaves two marks here: this slot is the match, and this
  // slot is at or past the match (those slots move down on a delete).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      sel_r   <= 1'b0;
      after_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_in.live) begin
        sel_r   <= first_hit;
        after_r <= tok_in.hit || key_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_APPEND: begin
        if (MyIdx == q_count) begin
          key_r   <= cmd.key;
          value_r <= cmd.value;
        end
      end
      CMD_REPLACE: begin
        if (sel_r) begin
          key_r   <= cmd.key;
          value_r <= cmd.value;
        end
      end
      CMD_SHIFT: begin
        if (after_r) begin
          key_r   <= nbr_key;
          value_r <= nbr_value;
        end
      end
      default: begin
      end
    endcase
  end

  assign tok_out   = tok_r;
  assign key_out   = key_r;
  assign value_out = value_r;

endmodule

// ----- src/keyed_entry_table_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_entry_table_unit: compacted key/name table of DEPTH slot cells
// Operations are taken one at a time, only while the table is idle; the scan
// token crosses one cell per cycle.
// Reset empties the table, sets capacity to 32; slot contents are not cleared.
// ----------------------------------------------------------------------------
module keyed_entry_table_unit #(
  parameter int DEPTH = kett_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kett_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kett_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [kett_pkg::CAP_W-1:0] cfg_wdata
);
  import kett_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT
  } state_t;

  state_t           state_r;
  in_item_t         req_r;
  logic             start_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] nc_r;
  logic [CAP_W-1:0] cap_r;
  cmd_t             cmd_r;
  out_item_t        res_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  token_t           tok [DEPTH+1];
  logic [KEY_W-1:0] slot_key [DEPTH];
  logic [VAL_W-1:0] slot_value [DEPTH];
  token_t           tail;

  logic [CMP_W-1:0] cap_eff;
  logic             full;
  status_t          status_nxt;
  logic [CNT_W-1:0] ncount_nxt;
  cmd_t             cmd_nxt;
  out_item_t        res_nxt;

  assign tok[0] = '{live: start_r, hit: 1'b0, nhit: 1'b0, fval: '0};
  assign tail   = tok[DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [KEY_W-1:0] nk;
    logic [VAL_W-1:0] nv;
    if (k == DEPTH - 1) begin : g_last
      assign nk = slot_key[k];
      assign nv = slot_value[k];
    end else begin : g_mid
      assign nk = slot_key[k+1];
      assign nv = slot_value[k+1];
    end
    kett_cell #(
      .DEPTH (DEPTH),
      .IDX   (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1]),
      .q_key     (req_r.key),
      .q_new_key (req_r.new_key),
      .q_count   (count_r),
      .cmd       (cmd_r),
      .nbr_key   (nk),
      .nbr_value (nv),
      .key_out   (slot_key[k]),
      .value_out (slot_value[k])
    );
  end

  assign cap_eff = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign full    = CMP_W'(count_r) >= cap_eff;

  always_comb begin
    status_nxt   = ST_OK;
    ncount_nxt   = count_r;
    cmd_nxt.op   = CMD_NONE;
    cmd_nxt.key  = req_r.key;
    cmd_nxt.value = req_r.value;
    res_nxt.found_key   = '0;
    res_nxt.found_value = '0;
    case (req_r.kind)
      KIND_ADD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (tail.hit) begin
          status_nxt = ST_DUP;
        end else begin
          cmd_nxt.op = CMD_APPEND;
          ncount_nxt = count_r + 1'b1;
        end
      end
      KIND_DEL: begin
        if (!tail.hit) begin
          status_nxt = ST_MISSING;
        end else begin
          cmd_nxt.op = CMD_SHIFT;
          ncount_nxt = count_r - 1'b1;
        end
      end
      KIND_GET: begin
        if (!tail.hit) begin
          status_nxt = ST_MISSING;
        end else begin
          res_nxt.found_key   = req_r.key;
          res_nxt.found_value = tail.fval;
        end
      end
      KIND_UPD: begin
        // The new key is checked first, the entry's own key included.
        if (tail.nhit) begin
          status_nxt = ST_COLLIDE;
        end else if (!tail.hit) begin
          status_nxt = ST_MISSING;
        end else begin
          cmd_nxt.op  = CMD_REPLACE;
          cmd_nxt.key = req_r.new_key;
        end
      end
      default: begin
      end
    endcase
    res_nxt.status      = status_nxt;
    res_nxt.entry_count = CNT_OUT_W'(ncount_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      cmd_r.op    <= CMD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      // In S_EMIT the valid flag is handled by the state below.
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= '{kind:    in_data.kind,
                         key:     in_data.key,
                         new_key: in_data.new_key,
                         value:   clean_name(in_data.value)};
            start_r <= 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.live) begin
            cmd_r   <= cmd_nxt;
            res_r   <= res_nxt;
            nc_r    <= ncount_nxt;
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          // Cells apply the command this cycle against the old count.
          cmd_r.op <= CMD_NONE;
          count_r  <= nc_r;
          state_r  <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/kett_checker.sv -----
// ----------------------------------------------------------------------------
// kett_checker: port-level checks for the keyed entry table
// Watches the item channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module kett_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kett_pkg::out_item_t out_data
);
  import kett_pkg::*;

  // A result beat that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The table works on one operation at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // Only a successful get carries an entry.
  a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.found_key == '0 && out_data.found_value == '0)
    else $error("failed operation returned an entry");

endmodule

bind keyed_entry_table_unit kett_checker u_kett_checker (.*);
